/* design/planar_odometry_integrator_unit_defines.svh */
// Assertion macros shared by the checker of the odometry integrator.
// No dependencies; files that assert include this header by its bare name.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define POI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication, disabled while reset is high.
`define POI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

/* design/poi_pkg.sv */
// Shared types, fixed-point widths and constants of the odometry integrator.
// No dependencies; the design files and the testbench refer to it by scoped names.
package poi_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle and pose widths.
  localparam int ANG_W = 32;
  localparam int POS_W = 40;
  localparam int HEAD_W = 16;

  // CORDIC datapath width (x, y and z carry headroom above Q30).
  localparam int CW = 34;
  localparam longint CORDIC_GAIN = 64'd652032874;

  // Rounding shifts.
  localparam int CS_SHIFT = 15;
  localparam int Q_SHIFT = 15;
  localparam int DX_SHIFT = 32;
  localparam int DH_SHIFT = 24;

  // Product widths.
  localparam int SPEED_W = 16;
  localparam int TIME_W = 20;
  localparam int P_W = SPEED_W + TIME_W + 1;
  localparam int CS_W = CW - CS_SHIFT;
  localparam int PX_W = P_W + CS_W;
  localparam int Q_W = PX_W - Q_SHIFT;
  localparam int SCALE_W = 20;
  localparam int M_W = Q_W + SCALE_W;
  localparam int DX_W = M_W - DX_SHIFT;
  localparam int HS_W = 23;
  localparam int HP_W = P_W + HS_W;

  localparam logic signed [SCALE_W-1:0] POS_SCALE = 20'sd274878;
  localparam logic signed [HS_W-1:0] HEAD_SCALE = 23'sd2799883;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [P_W-1:0] prod_t;
  typedef logic signed [DX_W-1:0] dx_t;

  // Data handed from one CORDIC cell to the next.
  typedef struct packed {
    logic valid;
    cw_t  x;
    cw_t  y;
    cw_t  z;
  } poi_cordic_t;

  // Pose increments handed from the scaling pipeline to the accumulators.
  typedef struct packed {
    logic             valid;
    dx_t              dx;
    dx_t              dy;
    logic [ANG_W-1:0] dh;
  } poi_delta_t;

  // atan(2^-i) in binary angle units, 2^32 per turn.
  function automatic logic [ANG_W-1:0] atan_angle(input int idx);
    logic [ANG_W-1:0] r;
    case (idx)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/planar_odometry_integrator_unit.sv */
// Top level of the planar odometry integrator: CORDIC cell chain, scaling
// pipeline and pose accumulators. Depends on poi_pkg, poi_cordic_cell, poi_scale.
//
// Usage. Each input transaction carries forward_speed, yaw_rate and elapsed_us.
// The block rotates by the heading held before the update, adds the x and y
// increments to the 40-bit position accumulators and then advances the 32-bit
// heading. Each input transaction yields exactly one output transaction with
// the new pose_x, pose_y and the top 16 bits of the heading.
//
// Timing. An accepted transaction enters the first of CORDIC_STEPS cells (clamped
// to 1..24) at the accepting edge and moves one cell per cycle, then passes five
// scaling stages and the accumulator update, which raises out_valid. The block
// works on one item at a time; in_ready returns high together with out_valid,
// and the next input can be taken from then on.
//
// Reset clears the accumulators, the pipeline valids and the output flag.
// When the receiver stalls, the result holds in the accumulators; a new input
// may still be accepted and computed, but its update waits at the last stage
// until the pending output transaction completes.
module planar_odometry_integrator_unit #(
  parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [poi_pkg::SPEED_W-1:0] forward_speed,
  input  logic signed [poi_pkg::SPEED_W-1:0] yaw_rate,
  input  logic [poi_pkg::TIME_W-1:0]         elapsed_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [poi_pkg::POS_W-1:0]   pose_x,
  output logic signed [poi_pkg::POS_W-1:0]   pose_y,
  output logic [poi_pkg::HEAD_W-1:0]         heading
);

  // Step count clamped to the arctangent table.
  localparam int STEPS = (CORDIC_STEPS < 1) ? 1 :
                         (CORDIC_STEPS > poi_pkg::ATAN_ENTRIES) ? poi_pkg::ATAN_ENTRIES :
                         CORDIC_STEPS;
  localparam int ANG_W = poi_pkg::ANG_W;
  localparam int POS_W = poi_pkg::POS_W;
  localparam int P_W = poi_pkg::P_W;
  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(1) <<< (ANG_W - 2);
  localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(1) << (ANG_W - 1);

  logic             busy;
  logic [POS_W-1:0] acc_x;
  logic [POS_W-1:0] acc_y;
  logic [ANG_W-1:0] acc_heading;
  poi_pkg::prod_t   p_r;
  poi_pkg::prod_t   wt_r;
  logic             neg_r;

  logic                    accept;
  logic                    take;
  logic signed [ANG_W-1:0] ang;
  logic                    fold;
  logic [ANG_W-1:0]        ang_fold;
  poi_pkg::poi_delta_t     delta;
  poi_pkg::poi_cordic_t    chain [STEPS+1];

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;

  // Fold the heading into [-quarter, +quarter] turn; the fold flips the
  // sign of both cosine and sine, which the scaling pipeline undoes.
  always_comb begin
    ang = $signed(acc_heading);
    fold = (ang > QUARTER) || (ang < -QUARTER);
    ang_fold = fold ? (acc_heading - HALF_TURN) : acc_heading;
  end

  assign chain[0] = '{valid: accept,
                      x: poi_pkg::cw_t'(poi_pkg::CORDIC_GAIN),
                      y: '0,
                      z: poi_pkg::cw_t'($signed(ang_fold))};

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    poi_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .cur(chain[g]),
      .nxt(chain[g+1])
    );
  end

  poi_scale u_scale (
    .clk(clk),
    .rst(rst),
    .cord(chain[STEPS]),
    .neg(neg_r),
    .p(p_r),
    .wt(wt_r),
    .take(take),
    .delta(delta)
  );

  // The accumulators change only when the output register is free, so the
  // pose ports hold steady for the whole of a stalled output transaction.
  assign take = delta.valid && (!out_valid || out_ready);

  // Speed and yaw-rate products with the time step are formed at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= P_W'(forward_speed) * P_W'($signed({1'b0, elapsed_us}));
      wt_r <= P_W'(yaw_rate) * P_W'($signed({1'b0, elapsed_us}));
      neg_r <= fold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      acc_x <= '0;
      acc_y <= '0;
      acc_heading <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (take) begin
        acc_x <= acc_x + POS_W'($signed(delta.dx));
        acc_y <= acc_y + POS_W'($signed(delta.dy));
        acc_heading <= acc_heading + delta.dh;
        out_valid <= 1'b1;
        busy <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pose_x = $signed(acc_x);
  assign pose_y = $signed(acc_y);
  assign heading = acc_heading[ANG_W-1 -: poi_pkg::HEAD_W];

endmodule

/* design/poi_cordic_cell.sv */
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on poi_pkg for the datapath types and the arctangent table.
module poi_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  poi_pkg::poi_cordic_t cur,
  output poi_pkg::poi_cordic_t nxt
);

  localparam poi_pkg::cw_t ANGLE = poi_pkg::cw_t'(poi_pkg::atan_angle(STAGE));

  logic         valid;
  poi_pkg::cw_t x;
  poi_pkg::cw_t y;
  poi_pkg::cw_t z;
  poi_pkg::cw_t x_next;
  poi_pkg::cw_t y_next;
  poi_pkg::cw_t z_next;
  poi_pkg::cw_t xs;
  poi_pkg::cw_t ys;
  logic         up;

  always_comb begin
    xs = $signed(cur.x) >>> STAGE;
    ys = $signed(cur.y) >>> STAGE;
    up = !cur.z[poi_pkg::CW-1];
    if (up) begin
      x_next = cur.x - ys;
      y_next = cur.y + xs;
      z_next = cur.z - ANGLE;
    end else begin
      x_next = cur.x + ys;
      y_next = cur.y - xs;
      z_next = cur.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cur.valid;
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
    z <= z_next;
  end

  assign nxt = '{valid: valid, x: x, y: y, z: z};

endmodule

/* design/poi_scale.sv */
// Fixed-point scaling pipeline: turns CORDIC x/y into cos/sin, forms the
// rounded position and heading increments. Depends on poi_pkg.
module poi_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  poi_pkg::poi_cordic_t cord,
  input  logic                 neg,
  input  poi_pkg::prod_t       p,
  input  poi_pkg::prod_t       wt,
  input  logic                 take,
  output poi_pkg::poi_delta_t  delta
);

  localparam int CW = poi_pkg::CW;
  localparam int CS_W = poi_pkg::CS_W;
  localparam int PX_W = poi_pkg::PX_W;
  localparam int Q_W = poi_pkg::Q_W;
  localparam int M_W = poi_pkg::M_W;
  localparam int HP_W = poi_pkg::HP_W;
  localparam int ANG_W = poi_pkg::ANG_W;

  localparam logic signed [CW-1:0] HALF_CS = CW'(1) <<< (poi_pkg::CS_SHIFT - 1);
  localparam logic signed [PX_W-1:0] HALF_Q = PX_W'(1) <<< (poi_pkg::Q_SHIFT - 1);
  localparam logic signed [M_W-1:0] HALF_DX = M_W'(1) <<< (poi_pkg::DX_SHIFT - 1);
  localparam logic signed [HP_W-1:0] HALF_DH = HP_W'(1) <<< (poi_pkg::DH_SHIFT - 1);

  logic a_valid;
  logic b_valid;
  logic c_valid;
  logic d_valid;
  logic e_valid;

  logic signed [CW-1:0]   xr;
  logic signed [CW-1:0]   yr;
  logic signed [CS_W-1:0] cs;
  logic signed [CS_W-1:0] sn;
  logic signed [CS_W-1:0] cs_r;
  logic signed [CS_W-1:0] sn_r;
  logic signed [PX_W-1:0] px_r;
  logic signed [PX_W-1:0] py_r;
  logic signed [PX_W-1:0] px_round;
  logic signed [PX_W-1:0] py_round;
  logic signed [Q_W-1:0]  qx_r;
  logic signed [Q_W-1:0]  qy_r;
  logic signed [M_W-1:0]  mx_r;
  logic signed [M_W-1:0]  my_r;
  logic signed [M_W-1:0]  mx_round;
  logic signed [M_W-1:0]  my_round;
  logic signed [HP_W-1:0] hp_r;
  logic signed [HP_W-1:0] hp_round;
  poi_pkg::dx_t           dx_r;
  poi_pkg::dx_t           dy_r;
  logic [ANG_W-1:0]       dh_r;

  always_comb begin
    xr = cord.x + HALF_CS;
    yr = cord.y + HALF_CS;
    cs = xr[CW-1:poi_pkg::CS_SHIFT];
    sn = yr[CW-1:poi_pkg::CS_SHIFT];
    px_round = px_r + HALF_Q;
    py_round = py_r + HALF_Q;
    mx_round = mx_r + HALF_DX;
    my_round = my_r + HALF_DX;
    hp_round = hp_r + HALF_DH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      a_valid <= cord.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      if (d_valid) begin
        e_valid <= 1'b1;
      end else if (take) begin
        e_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // Cosine and sine in Q15, with the half-turn fold undone.
    cs_r <= neg ? -cs : cs;
    sn_r <= neg ? -sn : sn;
    px_r <= PX_W'(p) * PX_W'(cs_r);
    py_r <= PX_W'(p) * PX_W'(sn_r);
    hp_r <= HP_W'(wt) * HP_W'(poi_pkg::HEAD_SCALE);
    if (b_valid) begin
      qx_r <= px_round[PX_W-1:poi_pkg::Q_SHIFT];
      qy_r <= py_round[PX_W-1:poi_pkg::Q_SHIFT];
    end
    mx_r <= M_W'(qx_r) * M_W'(poi_pkg::POS_SCALE);
    my_r <= M_W'(qy_r) * M_W'(poi_pkg::POS_SCALE);
    if (d_valid) begin
      dx_r <= mx_round[M_W-1:poi_pkg::DX_SHIFT];
      dy_r <= my_round[M_W-1:poi_pkg::DX_SHIFT];
      dh_r <= hp_round[poi_pkg::DH_SHIFT+ANG_W-1:poi_pkg::DH_SHIFT];
    end
  end

  assign delta = '{valid: e_valid, dx: dx_r, dy: dy_r, dh: dh_r};

endmodule

/* design/poi_checker.sv */
// Port-level checker for the odometry integrator, bound to the top level.
// Depends on poi_pkg and the assertion macros of the defines header.
`include "planar_odometry_integrator_unit_defines.svh"

module poi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [poi_pkg::SPEED_W-1:0] forward_speed,
  input logic signed [poi_pkg::SPEED_W-1:0] yaw_rate,
  input logic [poi_pkg::TIME_W-1:0]         elapsed_us,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [poi_pkg::POS_W-1:0]   pose_x,
  input logic signed [poi_pkg::POS_W-1:0]   pose_y,
  input logic [poi_pkg::HEAD_W-1:0]         heading
);

  // A pending result stays offered until it is taken.
  `POI_ASSERT_NEXT(ap_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // The pose does not move under a stalled output transaction.
  `POI_ASSERT_NEXT(ap_pose_stable, clk, rst, out_valid && !out_ready, $stable(pose_x) && $stable(pose_y) && $stable(heading))

  // Only one item is in flight: acceptance closes the input.
  `POI_ASSERT_NEXT(ap_one_item, clk, rst, in_valid && in_ready, !in_ready)

  // The input reopens only when a result has just been posted.
  `POI_ASSERT_NOW(ap_reopen, clk, rst, $rose(in_ready) && !$past(rst), out_valid)

endmodule

bind planar_odometry_integrator_unit poi_checker u_poi_checker (.*);

/* verif/tb_planar_odometry_integrator_unit.sv */
// Self-checking testbench for planar_odometry_integrator_unit (dead-reckoning pose update).
// Depends on poi_pkg for port widths and on the RTL of the block; it reads nothing else.
// A bit-exact pose predictor checks every output transaction against the integer math.
module tb_planar_odometry_integrator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  // One item in flight at a time; covers the cell chain, scaling and accumulate stages.
  localparam int ITEM_CYCLES = STEPS + 6;
  localparam int DRAIN_CYCLES = 4 * ITEM_CYCLES;
  localparam int RANDOM_STEPS = 680;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER = 300;

  // Fixed-point constants of the pose update.
  localparam longint CORDIC_START_X = 652032874;
  localparam longint QUARTER_TURN = 1073741824;
  localparam longint METRE_SCALE = 274878;
  localparam longint TURN_SCALE = 2799883;
  localparam int TRIG_SHIFT = 15;
  localparam int PROD_SHIFT = 15;
  localparam int METRE_SHIFT = 32;
  localparam int TURN_SHIFT = 24;

  localparam int SPW = poi_pkg::SPEED_W;
  localparam int TW = poi_pkg::TIME_W;
  localparam int PW = poi_pkg::POS_W;
  localparam int AW = poi_pkg::ANG_W;
  localparam int HW = poi_pkg::HEAD_W;

  // One odometry sample as it is offered on the input channel.
  typedef struct {
    logic signed [SPW-1:0] speed;
    logic signed [SPW-1:0] yaw;
    logic [TW-1:0]         dt;
  } odo_step_t;

  // The pose the block should report after a sample.
  typedef struct {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [HW-1:0] hdg;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SPW-1:0] forward_speed = '0;
  logic signed [SPW-1:0] yaw_rate = '0;
  logic [TW-1:0] elapsed_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PW-1:0] pose_x;
  logic signed [PW-1:0] pose_y;
  logic [HW-1:0] heading;

  // Predictor state: a private copy of the block's accumulators.
  logic [PW-1:0] est_x = '0;
  logic [PW-1:0] est_y = '0;
  logic [AW-1:0] est_heading = '0;

  // atan(2^-i) in binary angle units of 2^32 per turn.
  longint atan_units [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  odo_step_t pending_steps[$];
  pose_t expected_poses[$];
  int total_steps = 0;
  int accepted_count = 0;
  int mismatch_count = 0;

  planar_odometry_integrator_unit #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .forward_speed(forward_speed),
    .yaw_rate(yaw_rate),
    .elapsed_us(elapsed_us),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pose_x(pose_x),
    .pose_y(pose_y),
    .heading(heading)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Round half up, then shift right with floor semantics.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Rotation-mode CORDIC on the held heading, returning cos and sin in Q15.
  // Angles beyond a quarter turn are folded by half a turn and the results negated.
  function automatic void heading_cos_sin(input logic [AW-1:0] ang, output longint c,
                                          output longint s);
    longint a;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    logic [AW-1:0] folded;
    bit flip;
    int n;
    a = $signed(ang);
    flip = 1'b0;
    if (a > QUARTER_TURN || a < -QUARTER_TURN) begin
      folded = ang - 32'h8000_0000;
      a = $signed(folded);
      flip = 1'b1;
    end
    n = (STEPS < 1) ? 1 : ((STEPS > 24) ? 24 : STEPS);
    x = CORDIC_START_X;
    y = 0;
    z = a;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_units[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_units[i];
      end
    end
    c = round_shift(x, TRIG_SHIFT);
    s = round_shift(y, TRIG_SHIFT);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  // Euler step: move along the old heading, then turn. Updates the predictor state.
  function automatic pose_t advance_pose(input odo_step_t st);
    longint v;
    longint w;
    longint t;
    longint c;
    longint s;
    longint p;
    longint dx;
    longint dy;
    longint dh;
    pose_t r;
    v = st.speed;
    w = st.yaw;
    t = st.dt;
    heading_cos_sin(est_heading, c, s);
    p = v * t;
    dx = round_shift(round_shift(p * c, PROD_SHIFT) * METRE_SCALE, METRE_SHIFT);
    dy = round_shift(round_shift(p * s, PROD_SHIFT) * METRE_SCALE, METRE_SHIFT);
    dh = round_shift(w * t * TURN_SCALE, TURN_SHIFT);
    est_x = est_x + dx[PW-1:0];
    est_y = est_y + dy[PW-1:0];
    est_heading = est_heading + dh[AW-1:0];
    r.x = est_x;
    r.y = est_y;
    r.hdg = est_heading[AW-1:AW-HW];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic add_step(input int speed, input int yaw, input int dt);
    odo_step_t st;
    st.speed = SPW'(speed);
    st.yaw = SPW'(yaw);
    st.dt = TW'(dt);
    pending_steps.push_back(st);
    total_steps++;
  endtask

  // Input driver. The sender runs in bursts of random length separated by random
  // gaps; a zero gap is common so that back-to-back stretches also occur. The
  // expected pose is computed at the edge where the input transaction completes.
  always @(posedge clk) begin : step_driver
    odo_step_t st;
    odo_step_t nxt;
    int burst_left;
    int gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        st.speed = forward_speed;
        st.yaw = yaw_rate;
        st.dt = elapsed_us;
        expected_poses.push_back(advance_pose(st));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_steps.size() != 0) begin
          nxt = pending_steps.pop_front();
          forward_speed <= nxt.speed;
          yaw_rate <= nxt.yaw;
          elapsed_us <= nxt.dt;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure. The receiver switches between stall patterns every so
  // often: always ready, coin flip, mostly stalled, and a fixed duty cycle. Once in
  // the run it holds off for a long stretch while the sender keeps offering, so the
  // block fills and must stall its input.
  always @(posedge clk) begin : pose_sink
    int hold_left;
    bit hold_done;
    int pattern_left;
    int stall_mode;
    int unsigned tick;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      pattern_left = 0;
      stall_mode = 0;
      tick = 0;
    end else begin
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_OFF_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          pattern_left = $urandom_range(16, 200);
        end else begin
          pattern_left--;
        end
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= tick[2];
        endcase
      end
    end
  end

  // Output monitor: every completed output transaction is matched with the oldest
  // predicted pose, field by field.
  always @(posedge clk) begin : pose_checker
    pose_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("output transaction with no pending sample, pose_x", pose_x, 0);
      end else begin
        want = expected_poses.pop_front();
        if (pose_x !== want.x) report_mismatch("pose_x", pose_x, want.x);
        if (pose_y !== want.y) report_mismatch("pose_y", pose_y, want.y);
        if (heading !== want.hdg) report_mismatch("heading", heading, want.hdg);
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int kind;
    int sp;
    int yw;
    int dt;
    // Directed samples. Zero elapsed time must leave the pose unchanged, including
    // with nonzero speed and yaw. The big turns push the heading past a quarter turn
    // so that the folded half of the CORDIC range is exercised early.
    add_step(0, 0, 0);
    add_step(32767, 0, 1048575);
    add_step(-32768, 0, 1048575);
    add_step(1234, -5000, 0);
    add_step(1000, 32767, 1048575);
    add_step(32767, 0, 1048575);
    add_step(-32768, -32768, 1048575);
    add_step(32767, 32767, 1048575);
    add_step(-32768, 0, 1048575);
    add_step(5, 1, 1);
    add_step(-1, -1, 1);
    add_step(32767, 32767, 0);
    add_step(-32768, -32768, 0);
    add_step(20000, 16384, 800000);
    add_step(-20000, 16384, 800000);
    add_step(12000, -32768, 524288);
    add_step(32767, -1, 1048575);
    add_step(0, 32767, 1048575);
    add_step(-32768, 12345, 1048575);
    add_step(32767, 0, 1);

    // Random samples: mostly realistic control-loop updates, some wholly random
    // fields, some zero time steps and some full-scale extremes.
    for (int n = 0; n < RANDOM_STEPS; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          sp = $signed(16'($urandom));
          yw = $signed(16'($urandom));
          dt = $urandom_range(0, 1048575);
        end
        2: begin
          sp = $signed(16'($urandom));
          yw = $signed(16'($urandom));
          dt = 0;
        end
        3: begin
          sp = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
          yw = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? -32768 : 32767);
          dt = ($urandom_range(0, 1) == 0) ? 1048575 : $urandom_range(1, 1048575);
        end
        default: begin
          sp = $signed(13'($urandom));
          yw = $signed(13'($urandom));
          dt = $urandom_range(1000, 50000);
        end
      endcase
      add_step(sp, yw, dt);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count != total_steps) @(posedge clk);
    while (expected_poses.size() != 0) @(posedge clk);
    // Let anything stray come out before judging the run.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("planar_odometry_integrator_unit: match");
    end else begin
      $display("planar_odometry_integrator_unit: mismatch");
    end
    $finish;
  end

  // Watchdog, set well above the slowest legal run with every stall pattern.
  initial begin : watchdog
    #2_000_000;
    $display("planar_odometry_integrator_unit: mismatch");
    $finish;
  end

endmodule
